>>> design/rational_arith_reduce_core_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef RATIONAL_ARITH_REDUCE_CORE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_CORE_MACROS_SVH
// implication checked every clock outside reset
`define RAR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define RAR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> design/rar_pkg.sv
// Package for the rational arithmetic core: payload structs, opcodes, FSM states.
// No dependencies.
package rar_pkg;
  localparam int OperandBits = 16;
  localparam int NumBits     = 2 * OperandBits + 1;
  localparam int DenBits     = 2 * OperandBits;
  localparam int CntBits     = $clog2(NumBits + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                        opcode;
    logic signed [OperandBits-1:0]  left_num;
    logic        [OperandBits-1:0]  left_den;
    logic signed [OperandBits-1:0]  right_num;
    logic        [OperandBits-1:0]  right_den;
  } in_beat_t;

  typedef struct packed {
    logic signed [NumBits-1:0] out_num;
    logic        [DenBits-1:0] out_den;
    logic                      status;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_FORM,
    ST_GCD_START,
    ST_GCD_DIV,
    ST_GCD_SWAP,
    ST_RED_N_START,
    ST_RED_N,
    ST_RED_D_START,
    ST_RED_D,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic form;
    logic gcd_start;
    logic div_step;
    logic gcd_swap;
    logic red_n_start;
    logic red_n_done;
    logic red_d_start;
    logic red_d_done;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic num_zero;
    logic div_last;
    logic rem_zero;
  } dp_sts_t;
endpackage

>>> design/rar_datapath.sv
// Datapath: cross products, sign handling, shared restoring divider for gcd and reduction.
// Depends on rar_pkg.
module rar_datapath
  import rar_pkg::*;
(
  input  logic      clk,
  input  in_beat_t  in_beat,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_beat_t res
);
  localparam int W = DenBits;
  localparam int OB = OperandBits;

  in_beat_t              op_r;
  logic signed [2*OB:0]  p1_r, p2_r;
  logic [W-1:0]          den_r;
  logic [W-1:0]          mag_r;
  logic                  neg_r, bad_r;
  logic [W-1:0]          ga_r, gb_r;
  // divider
  logic [W-1:0]          dvd_r, dvs_r, quo_r;
  logic [W:0]            rem_r;
  logic [CntBits-1:0]    cnt_r;
  logic [W-1:0]          g_r;
  logic signed [NumBits-1:0] qnum_r;
  out_beat_t             res_r;

  logic signed [OB:0] ln_e, rn_e, ld_e, rd_e;
  logic signed [OB:0] ma, mb, mc, md;
  logic signed [2*OB+1:0] num_s, den_s;
  logic [W:0] rem_sh, rem_sub;
  logic num_zero;

  assign ln_e = {op_r.left_num[OB-1], op_r.left_num};
  assign rn_e = {op_r.right_num[OB-1], op_r.right_num};
  assign ld_e = {1'b0, op_r.left_den};
  assign rd_e = {1'b0, op_r.right_den};

  // operand select for the two products
  always_comb begin
    ma = ln_e; mb = rd_e; mc = rn_e; md = ld_e;
    unique case (op_r.opcode)
      OP_MUL:  begin mb = rn_e; mc = ld_e; md = rd_e; end
      OP_DIV:  begin mb = rd_e; mc = ld_e; md = rn_e; end
      default: begin mb = rd_e; mc = rn_e; md = ld_e; end
    endcase
  end

  // combine products into signed num / den
  always_comb begin
    num_s = {p1_r[2*OB], p1_r};
    den_s = {p2_r[2*OB], p2_r};
    unique case (op_r.opcode)
      OP_ADD:  num_s = {p1_r[2*OB], p1_r} + {p2_r[2*OB], p2_r};
      OP_SUB:  num_s = {p1_r[2*OB], p1_r} - {p2_r[2*OB], p2_r};
      default: num_s = {p1_r[2*OB], p1_r};
    endcase
    if (op_r.opcode == OP_ADD || op_r.opcode == OP_SUB) begin
      den_s = (2*OB+2)'($unsigned(op_r.left_den) * $unsigned(op_r.right_den));
    end
    if (den_s < 0) begin
      den_s = -den_s;
      num_s = -num_s;
    end
  end

  assign rem_sh  = {rem_r[W-1:0], dvd_r[W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_beat;
    end
    if (cmd.mul1) begin
      p1_r <= (2*OB+1)'(ma * mb);
      bad_r <= (op_r.left_den == '0) || (op_r.right_den == '0) ||
               (op_r.opcode == OP_DIV && op_r.right_num == '0);
    end
    if (cmd.mul2) begin
      p2_r <= (2*OB+1)'(mc * md);
    end
    if (cmd.form) begin
      neg_r <= num_s[2*OB+1];
      mag_r <= W'(num_s[2*OB+1] ? -num_s : num_s);
      den_r <= W'(den_s);
      ga_r  <= W'(num_s[2*OB+1] ? -num_s : num_s);
      gb_r  <= W'(den_s);
    end
    // divider start: a / b, or mag / g, or den / g
    if (cmd.gcd_start || cmd.red_n_start || cmd.red_d_start) begin
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
      dvd_r <= cmd.gcd_start ? ga_r : (cmd.red_n_start ? mag_r : den_r);
      dvs_r <= cmd.gcd_start ? gb_r : g_r;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
      if (!rem_sub[W]) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
    if (cmd.gcd_swap) begin
      ga_r <= gb_r;
      gb_r <= rem_r[W-1:0];
      g_r  <= gb_r;
    end
    // reduced numerator waits here until the result is published
    if (cmd.red_n_done) begin
      qnum_r <= neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    end
    // publish; invalid or zero results read 0/1
    if (cmd.red_d_done) begin
      if (bad_r || num_zero) begin
        res_r.out_num <= '0;
        res_r.out_den <= DenBits'(1);
        res_r.status  <= bad_r;
      end else begin
        res_r.out_num <= qnum_r;
        res_r.out_den <= quo_r;
        res_r.status  <= 1'b0;
      end
    end
  end

  assign num_zero = (p1_r == '0 && op_r.opcode != OP_ADD && op_r.opcode != OP_SUB) ||
                    (num_s == '0);
  assign sts.bad      = bad_r;
  assign sts.num_zero = num_zero;
  assign sts.div_last = (cnt_r == CntBits'(W - 1));
  assign sts.rem_zero = (rem_r == '0);
  assign res = res_r;
endmodule

>>> design/rar_ctrl.sv
// Controller FSM: sequences products, gcd loop and the two reduction divisions.
// Depends on rar_pkg.
module rar_ctrl
  import rar_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);
  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin cmd.mul1 = 1'b1; state_nxt = ST_MUL2; end
      ST_MUL2: begin cmd.mul2 = 1'b1; state_nxt = ST_FORM; end
      ST_FORM: begin
        cmd.form = 1'b1;
        state_nxt = (sts.bad || sts.num_zero) ? ST_DONE : ST_GCD_START;
      end
      ST_GCD_START: begin cmd.gcd_start = 1'b1; state_nxt = ST_GCD_DIV; end
      ST_GCD_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_GCD_SWAP;
      end
      ST_GCD_SWAP: begin
        cmd.gcd_swap = 1'b1;
        state_nxt = sts.rem_zero ? ST_RED_N_START : ST_GCD_START;
      end
      ST_RED_N_START: begin cmd.red_n_start = 1'b1; state_nxt = ST_RED_N; end
      ST_RED_N: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_RED_D_START;
      end
      ST_RED_D_START: begin
        cmd.red_n_done = 1'b1; cmd.red_d_start = 1'b1; state_nxt = ST_RED_D;
      end
      ST_RED_D: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // wait for the previous result to drain before publishing
        if (!ov_r || out_ready) begin
          cmd.red_d_done = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
endmodule

>>> design/rational_arith_reduce_core.sv
// Top level of the rational arithmetic core: controller plus datapath.
// Depends on rar_pkg, rar_ctrl, rar_datapath.
//
// One fraction operation per input beat, one result beat each. A zero result
// numerator or invalid operands skip straight from the products to the result;
// otherwise the core runs k Euclid remainder steps (at least one) and then the
// two reduction divisions. The core takes no new beat until the current one is
// finished. Each remainder and both reduction quotients come from one
// shared 32-step restoring divider. A finished result waits in the output
// register while the next beat is taken and worked on; the core only stalls in
// its done state if that register is still full.
module rational_arith_reduce_core
  import rar_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  rar_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  rar_datapath u_dp (
    .clk, .in_beat(in_data), .cmd, .sts, .res(out_data)
  );
endmodule

>>> design/rar_checker.sv
// Port-level checker for the rational arithmetic core, bound to the top level.
// Depends on rar_pkg and the macro header.
`include "rational_arith_reduce_core_macros.svh"
module rar_checker
  import rar_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);
  `RAR_ASSERT_IMP(a_den_pos, clk, rst_n, out_valid, out_data.out_den != '0, "zero denominator")
  `RAR_ASSERT_IMP(a_bad_form, clk, rst_n, out_valid && out_data.status,
    out_data.out_num == '0 && out_data.out_den == DenBits'(1), "bad status without 0/1")
  `RAR_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data), "result changed while stalled")
  `RAR_ASSERT_NXT(a_one_busy, clk, rst_n, in_valid && in_ready, !in_ready, "took two beats")
endmodule

bind rational_arith_reduce_core rar_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
